// ----- hdl/glzw_pkg.sv -----
// shared constants for the gif lzw decoder
`default_nettype none
package glzw_pkg;
  localparam int TableEntriesDefault = 4096;
  localparam int MaxCodeBitsDefault = 12;
  localparam logic [3:0] MinSizeReset = 4'd8;
  localparam logic OpPush = 1'b0;
  localparam logic OpPull = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic restart;
    logic take_byte;
    logic pull;
    logic extract;
    logic walk_step;
    logic walk_root;
    logic commit;
  } glzw_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic size_ok;
    logic done;
    logic stack_empty;
    logic code_ready;
    logic need_walk;
    logic walk_more;
    logic blk_zero;
  } glzw_stat_t;
endpackage
`default_nettype wire

// ----- hdl/glzw_datapath.sv -----
// gif lzw datapath: bit buffer, code tables, expansion stack
`default_nettype none
module glzw_datapath #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int MAX_CODE_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic [7:0] byte_in,
  input  wire glzw_pkg::glzw_cmd_t cmd,
  output glzw_pkg::glzw_stat_t stat,
  output logic [7:0] pix_out
);
  import glzw_pkg::*;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SW = AW + 1;

  logic walk_phase;
  logic [11:0] prefix_mem [TABLE_ENTRIES];
  logic [7:0]  suffix_mem [TABLE_ENTRIES];
  logic [7:0]  stack_mem  [TABLE_ENTRIES];

  logic [3:0]  min_size;
  logic [SW-1:0] stack_count;
  logic [19:0] bit_buffer;
  logic [4:0]  bits_held;
  logic [3:0]  code_width;
  logic [12:0] next_slot, slot_limit;
  logic [11:0] previous_code, cur_code, code_in;
  logic [7:0]  first_char, block_bytes_left;
  logic after_clear, done_flag;
  logic [11:0] rd_prefix;
  logic [7:0]  rd_suffix;

  // derived quantities
  logic size_ok;
  logic [3:0] sz;
  logic [12:0] clear_code;
  logic [11:0] raw_code, mask;
  assign size_ok = (min_size >= 4'd2) && (min_size <= 4'd8);
  assign sz = size_ok ? min_size : 4'd8;
  assign clear_code = 13'd1 << min_size;
  assign mask = 12'((13'd1 << code_width) - 13'd1);
  assign raw_code = bit_buffer[11:0] & mask;

  assign stat.size_ok = size_ok;
  assign stat.done = done_flag;
  assign stat.stack_empty = (stack_count == '0);
  assign stat.code_ready = (bits_held >= {1'b0, code_width});
  assign stat.blk_zero = (block_bytes_left == 8'd0);
  // set by an extract that needs a table walk, cleared on commit
  assign stat.need_walk = walk_phase;
  // walk continues while code is a table code and stack has room
  assign stat.walk_more = ({1'b0, cur_code} >= clear_code + 13'd2) &&
                          (stack_count < SW'(TABLE_ENTRIES - 1));

  // table read for the walk (registered)
  always_ff @(posedge clk) begin
    rd_prefix <= prefix_mem[cur_code[AW-1:0]];
    rd_suffix <= suffix_mem[cur_code[AW-1:0]];
  end

  // stack pop read
  logic [SW-1:0] pop_idx;
  assign pop_idx = stack_count - SW'(1);
  always_ff @(posedge clk) begin
    if (cmd.pull) pix_out <= stack_mem[pop_idx[AW-1:0]];
  end

  // stack push
  logic push_en;
  logic [7:0] push_val;
  always_comb begin
    push_en = 1'b0;
    push_val = 8'd0;
    if (cmd.extract && !(raw_code == 12'(clear_code + 13'd1)) &&
        !(raw_code == 12'(clear_code))) begin
      if (after_clear) begin
        push_en = 1'b1;
        push_val = ({1'b0, raw_code} >= next_slot) ? 8'd0 : raw_code[7:0];
      end else if ({1'b0, raw_code} >= next_slot) begin
        push_en = 1'b1;
        push_val = first_char;
      end
    end else if (cmd.walk_step) begin
      push_en = 1'b1;
      push_val = rd_suffix;
    end else if (cmd.walk_root) begin
      push_en = 1'b1;
      push_val = cur_code[7:0];
    end
  end
  always_ff @(posedge clk) begin
    if (push_en && stack_count < SW'(TABLE_ENTRIES))
      stack_mem[stack_count[AW-1:0]] <= push_val;
  end

  // table write on commit
  always_ff @(posedge clk) begin
    if (cmd.commit && next_slot < slot_limit) begin
      suffix_mem[next_slot[AW-1:0]] <= cur_code[7:0];
      prefix_mem[next_slot[AW-1:0]] <= previous_code;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      min_size <= rst ? MinSizeReset : cfg_data;
    end
    if (rst || cfg_we || cmd.restart) begin
      stack_count <= '0;
      bit_buffer <= '0;
      bits_held <= '0;
      previous_code <= '0;
      first_char <= '0;
      block_bytes_left <= '0;
      after_clear <= 1'b0;
      done_flag <= 1'b0;
      cur_code <= '0;
      code_in <= '0;
      walk_phase <= 1'b0;
      code_width <= 4'(rst ? 4'd9 : ((cfg_data >= 4'd2 && cfg_data <= 4'd8) ?
                    cfg_data + 4'd1 : 4'd9));
      next_slot <= rst ? 13'd258 : ((cfg_data >= 4'd2 && cfg_data <= 4'd8) ?
                   (13'd1 << cfg_data) + 13'd2 : 13'd258);
      slot_limit <= rst ? 13'd512 : ((cfg_data >= 4'd2 && cfg_data <= 4'd8) ?
                    13'd2 << cfg_data : 13'd512);
    end else begin
      if (push_en && stack_count < SW'(TABLE_ENTRIES))
        stack_count <= stack_count + SW'(1);
      if (cmd.pull) stack_count <= stack_count - SW'(1);
      if (cmd.take_byte) begin
        if (block_bytes_left == 8'd0) begin
          if (byte_in == 8'd0) done_flag <= 1'b1;
          else block_bytes_left <= byte_in;
        end else begin
          block_bytes_left <= block_bytes_left - 8'd1;
          bit_buffer <= bit_buffer | 20'({12'd0, byte_in} << bits_held);
          bits_held <= bits_held + 5'd8;
        end
      end
      if (cmd.extract) begin
        bit_buffer <= bit_buffer >> code_width;
        bits_held <= bits_held - {1'b0, code_width};
        code_in <= raw_code;
        if (raw_code == 12'(clear_code + 13'd1)) begin
          done_flag <= 1'b1;
        end else if (raw_code == 12'(clear_code)) begin
          code_width <= sz + 4'd1;
          next_slot <= (13'd1 << sz) + 13'd2;
          slot_limit <= 13'd2 << sz;
          after_clear <= 1'b1;
        end else if (after_clear) begin
          after_clear <= 1'b0;
          previous_code <= ({1'b0, raw_code} >= next_slot) ? 12'd0 : raw_code;
          first_char <= ({1'b0, raw_code} >= next_slot) ? 8'd0 : raw_code[7:0];
        end else begin
          cur_code <= ({1'b0, raw_code} >= next_slot) ? previous_code : raw_code;
          walk_phase <= 1'b1;
        end
      end
      if (cmd.walk_step) cur_code <= rd_prefix;
      if (cmd.commit) begin
        walk_phase <= 1'b0;
        if (next_slot < slot_limit) begin
          first_char <= cur_code[7:0];
          next_slot <= next_slot + 13'd1;
          previous_code <= code_in;
          if (next_slot + 13'd1 >= slot_limit && code_width < 4'(MAX_CODE_BITS)) begin
            slot_limit <= slot_limit << 1;
            code_width <= code_width + 4'd1;
          end
        end else if (code_width < 4'(MAX_CODE_BITS)) begin
          slot_limit <= slot_limit << 1;
          code_width <= code_width + 4'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/glzw_control.sv -----
// gif lzw controller: request handling and decode sequencing
`default_nettype none
module glzw_control (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic in_fire,
  input  wire logic in_op,
  input  wire logic out_free,
  input  wire glzw_pkg::glzw_stat_t stat,
  output glzw_pkg::glzw_cmd_t cmd,
  output logic busy,
  output logic res_load,
  output logic res_valid_pix,
  output logic res_refused
);
  import glzw_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_RD = 3'd2,
                         S_WALK = 3'd3, S_DONE = 3'd4, S_PULLW = 3'd5;
  logic [2:0] state, state_next;
  logic pend_refused, pend_pix;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    res_load = 1'b0;
    res_valid_pix = pend_pix;
    res_refused = pend_refused;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (!stat.size_ok) begin
            state_next = S_DONE;
          end else if (in_op == OpPush) begin
            if (!(stat.done || !stat.stack_empty)) begin
              cmd.take_byte = 1'b1;
              state_next = stat.blk_zero ? S_DONE : S_DEC;
            end else state_next = S_DONE;
          end else if (!stat.stack_empty) begin
            cmd.pull = 1'b1;
            state_next = S_DEC;
          end else state_next = S_DONE;
        end
      end
      // extract codes while nothing is pending
      S_DEC: begin
        if (!stat.done && stat.stack_empty && stat.code_ready) begin
          cmd.extract = 1'b1;
          state_next = S_RD;
        end else state_next = S_DONE;
      end
      S_RD: state_next = stat.need_walk ? S_WALK : S_DEC;
      S_WALK: begin
        if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
          state_next = S_PULLW;
        end else begin
          cmd.walk_root = 1'b1;
          cmd.commit = 1'b1;
          state_next = S_DEC;
        end
      end
      S_PULLW: state_next = S_WALK;
      S_DONE: begin
        if (out_free) begin
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
      pend_refused <= 1'b0;
      pend_pix <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_fire) begin
        pend_pix <= stat.size_ok && in_op == OpPull && !stat.stack_empty;
        pend_refused <= !stat.size_ok ||
          (in_op == OpPush && (stat.done || !stat.stack_empty)) ||
          (in_op == OpPull && stat.stack_empty);
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/gif_lzw_decoder.sv -----
// gif lzw decoder top level
// Push stream bytes (op=0) or pull pixels (op=1), one request at a time; each
// request gives one result. A request goes via S_DEC, which extracts codes while
// no pixel is pending, to S_DONE, but skips S_DEC if refused or a length byte.
// Each code passes S_RD; a table walk adds S_WALK and S_PULLW per chained entry
// (registered table read), then S_WALK for root and commit. A result waiting in
// the full output register stalls the input. Writing min_code_size restarts the
// stream and is taken only while the block is idle with no result waiting.
`default_nettype none
module gif_lzw_decoder
  import glzw_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault,
  parameter int MAX_CODE_BITS = MaxCodeBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [3:0] cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic op,
  input  wire logic [7:0] stream_byte,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] pixel,
  output logic pixel_valid,
  output logic need_byte,
  output logic finished,
  output logic refused
);
  glzw_cmd_t cmd;
  glzw_stat_t stat;
  logic busy, res_load, res_pix, res_ref, cfg_we, in_fire;
  logic [7:0] pix_raw;

  assign cfg_ready = !busy && !out_valid;
  assign cfg_we = cfg_valid && cfg_ready;
  assign in_stall = busy;
  assign in_fire = in_valid && !busy;

  glzw_control u_ctl (
    .clk, .rst, .cfg_we, .in_fire, .in_op(op), .out_free(!out_valid || !out_stall),
    .stat, .cmd, .busy, .res_load,
    .res_valid_pix(res_pix), .res_refused(res_ref)
  );
  glzw_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .byte_in(stream_byte), .cmd, .stat,
    .pix_out(pix_raw)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (res_load) begin
      pixel <= res_pix ? pix_raw : 8'd0;
      pixel_valid <= res_pix;
      refused <= res_ref;
      need_byte <= stat.size_ok && !stat.done && stat.stack_empty;
      finished <= !stat.size_ok || stat.done;
    end
  end
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// testbench for the gif lzw decoder: stream-aware stimulus and a pixel scoreboard
module tb;
  import glzw_pkg::*;

  // scoreboard: decoder state copy and queue of expected results
  class pixel_scoreboard;
    logic [11:0] prefix_mem[4096];
    logic [7:0] suffix_mem[4096];
    logic [7:0] pix_stack[4096];
    int unsigned min_size, depth, bitbuf, held, width, nslot, limit;
    int unsigned prev_code, first_ch, blk_left;
    bit after_clr, done;
    logic [11:0] pending_q[$];
    int errors;

    function new();
      min_size = MinSizeReset;
      errors = 0;
      foreach (prefix_mem[i]) begin
        prefix_mem[i] = '0;
        suffix_mem[i] = '0;
        pix_stack[i] = '0;
      end
      restart();
    endfunction

    function bit size_ok();
      return min_size >= 2 && min_size <= 8;
    endfunction

    function void restart_width();
      int unsigned sz;
      sz = size_ok() ? min_size : 8;
      width = sz + 1;
      nslot = (1 << sz) + 2;
      limit = 1 << width;
    endfunction

    function void restart();
      depth = 0;
      bitbuf = 0;
      held = 0;
      prev_code = 0;
      first_ch = 0;
      blk_left = 0;
      after_clr = 0;
      done = 0;
      restart_width();
    endfunction

    function void set_min_size(logic [3:0] v);
      min_size = v;
      restart();
    endfunction

    function void stack_pixel(int unsigned v);
      if (depth < 4096) begin
        pix_stack[depth] = v[7:0];
        depth++;
      end
    endfunction

    // expand one code into the pixel stack and grow the table
    function void expand_code(int unsigned c);
      int unsigned clr, code;
      clr = 1 << min_size;
      if (c == clr + 1) begin
        done = 1;
        return;
      end
      if (c == clr) begin
        restart_width();
        after_clr = 1;
        return;
      end
      if (after_clr) begin
        after_clr = 0;
        if (c >= nslot) c = 0;
        prev_code = c;
        first_ch = c & 8'hFF;
        stack_pixel(c);
        return;
      end
      code = c;
      if (code >= nslot) begin
        code = prev_code;
        stack_pixel(first_ch);
      end
      while (code >= clr + 2 && depth < 4095) begin
        stack_pixel(suffix_mem[code % 4096]);
        code = prefix_mem[code % 4096];
      end
      stack_pixel(code);
      if (nslot < limit) begin
        first_ch = code & 8'hFF;
        suffix_mem[nslot % 4096] = first_ch[7:0];
        prefix_mem[nslot % 4096] = prev_code[11:0];
        nslot++;
        prev_code = c;
      end
      if (nslot >= limit && width < 12) begin
        limit = limit << 1;
        width++;
      end
    endfunction

    function void drain_bits();
      int unsigned c;
      while (!done && depth == 0 && held >= width) begin
        c = bitbuf & ((1 << width) - 1);
        bitbuf = bitbuf >> width;
        held -= width;
        expand_code(c);
      end
    endfunction

    // accepted request: update state, queue expected result
    function void note_request(logic o, logic [7:0] b);
      logic [7:0] pix;
      logic pv, rf;
      pix = 0;
      pv = 0;
      rf = 0;
      if (!size_ok()) begin
        rf = 1;
      end else if (o == OpPush) begin
        if (done || depth != 0) begin
          rf = 1;
        end else if (blk_left == 0) begin
          if (b == 0) done = 1;
          else blk_left = b;
        end else begin
          blk_left--;
          bitbuf = (bitbuf | (int'(b) << held)) & 32'hFFFFF;
          held += 8;
          drain_bits();
        end
      end else begin
        if (depth == 0) begin
          rf = 1;
        end else begin
          depth--;
          pix = pix_stack[depth];
          pv = 1;
          drain_bits();
        end
      end
      pending_q.push_back({pix, pv, size_ok() && !done && depth == 0,
                           !size_ok() || done, rf});
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] p, logic pv, logic nb, logic fin, logic rf);
      logic [11:0] e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result pixel %0d", $time, p);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("pixel", e[11:4], p);
      cmp("pixel_valid", e[3], pv);
      cmp("need_byte", e[2], nb);
      cmp("finished", e[1], fin);
      cmp("refused", e[0], rf);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [3:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  logic op = 0;
  logic [7:0] stream_byte = 0;
  logic out_valid, out_stall = 0;
  logic [7:0] pixel;
  logic pixel_valid, need_byte, finished, refused;

  pixel_scoreboard sb = new();
  int n_items = 0, burst_left = 1, quiet = 0;
  bit hold_req = 0, hold_armed = 0;
  int hold_left = 0, rx_mode = 0, rx_cnt = 0;
  logic [7:0] feed_q[$];
  logic [7:0] pk_data[$];
  longint pk_acc;
  int pk_nb;

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .stream_byte(stream_byte),
    .out_valid(out_valid), .out_stall(out_stall), .pixel(pixel),
    .pixel_valid(pixel_valid), .need_byte(need_byte), .finished(finished),
    .refused(refused)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(pixel, pixel_valid, need_byte, finished, refused);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_stall <= 1;
    end else begin
      rx_cnt++;
      if (rx_cnt % 50 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // send one request, called at a falling edge, returns at a falling edge
  task automatic offer(logic o, logic [7:0] b);
    in_valid <= 1;
    op <= o;
    stream_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(o, b);
    n_items++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  // wait for all results, let the block settle, then write min_code_size
  task automatic write_min_size(logic [3:0] v);
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_min_size(v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic void pack_code(int code, int w);
    pk_acc = pk_acc | (longint'(code) << pk_nb);
    pk_nb += w;
    while (pk_nb >= 8) begin
      pk_data.push_back(pk_acc[7:0]);
      pk_acc = pk_acc >> 8;
      pk_nb -= 8;
    end
  endfunction

  // encode a mostly legal code sequence and wrap it in sub-blocks
  task automatic build_stream(int msz, int ncodes, int litpct, bit use_end);
    int clr, w, ns, lim, code, r, idx, len;
    bit ac;
    clr = 1 << msz;
    w = msz + 1;
    ns = clr + 2;
    lim = 1 << w;
    ac = 0;
    pk_acc = 0;
    pk_nb = 0;
    pk_data.delete();
    for (int i = 0; i < ncodes; i++) begin
      if (i == 0 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0)) begin
        pack_code(clr, w);
        w = msz + 1;
        ns = clr + 2;
        lim = 1 << w;
        ac = 1;
        continue;
      end
      if (ac) begin
        // first code after a clear, sometimes beyond the next slot
        if ($urandom_range(0, 7) == 0 && ns < lim) code = $urandom_range(ns, lim - 1);
        else code = $urandom_range(0, clr - 1);
        ac = 0;
        pack_code(code, w);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < litpct) code = $urandom_range(0, clr - 1);
      else if (r < litpct + (100 - litpct) / 2 && ns > clr + 2)
        code = $urandom_range(clr + 2, ns - 1);
      else if (ns < 4096) code = ns;
      else code = $urandom_range(0, clr - 1);
      pack_code(code, w);
      if (ns < lim) ns++;
      if (ns >= lim && w < 12) begin
        lim = lim << 1;
        w++;
      end
    end
    if (use_end) pack_code(clr + 1, w);
    if (pk_nb > 0) pk_data.push_back(pk_acc[7:0]);
    feed_q.delete();
    idx = 0;
    while (idx < pk_data.size()) begin
      len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 16);
      if (len > pk_data.size() - idx) len = pk_data.size() - idx;
      feed_q.push_back(len[7:0]);
      for (int k = 0; k < len; k++) feed_q.push_back(pk_data[idx + k]);
      idx += len;
    end
    feed_q.push_back(8'd0);
  endtask

  // configure, then push bytes and pull pixels as the decoder asks
  task automatic run_stream(int msz, int ncodes, int litpct, bit use_end, bit may_abort);
    int fi, stop_at;
    build_stream(msz, ncodes, litpct, use_end);
    write_min_size(msz[3:0]);
    // long receiver hold while this stream is being offered
    if (hold_armed) begin
      hold_armed = 0;
      hold_req = 1;
    end
    fi = 0;
    stop_at = (may_abort && $urandom_range(0, 14) == 0) ?
              $urandom_range(1, feed_q.size()) : -1;
    forever begin
      if (sb.depth != 0) begin
        if ($urandom_range(0, 19) == 0) offer(OpPush, 8'($urandom));
        else offer(OpPull, 8'($urandom));
      end else if (sb.done || fi >= feed_q.size() || fi == stop_at) begin
        if ($urandom_range(0, 2) == 0) offer(OpPush, 8'($urandom));
        break;
      end else if ($urandom_range(0, 19) == 0) begin
        offer(OpPull, 8'($urandom));
      end else begin
        offer(OpPush, feed_q[fi]);
        fi++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: pull on an empty decoder, empty sub-block ends data
    offer(OpPull, 8'hFF);
    offer(OpPush, 8'h00);
    offer(OpPush, 8'hFF);
    // invalid minimum sizes leave the decoder inert
    write_min_size(4'd0);
    offer(OpPush, 8'h05);
    offer(OpPull, 8'h00);
    write_min_size(4'd9);
    offer(OpPush, 8'hAA);
    write_min_size(4'd15);
    offer(OpPull, 8'h55);
    run_stream(8, 5, 50, 1, 0);
    run_stream(2, 6, 30, 0, 0);

    // random streams, with one long receiver hold early on
    hold_armed = 1;
    while (n_items < 330) run_stream($urandom_range(2, 8), $urandom_range(4, 40),
                                     $urandom_range(20, 80),
                                     1'($urandom_range(0, 1)), 1);
    run_stream(8, 30, 40, 1, 0);

    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/glzw_pkg.sv
hdl/glzw_datapath.sv
hdl/glzw_control.sv
hdl/gif_lzw_decoder.sv
bench/tb.sv
